@@ rtl/lkp_pkg.sv @@
// Shared types and constants for the LED/key panel serial master.
// Holds the command codes, the sequencer step type and the queue/result records.
// No dependencies.
package lkp_pkg;

  // Request command codes (code 3 means nothing and is dropped)
  localparam logic [1:0] CMD_SEND  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Fixed bytes sent on the bus
  localparam logic [7:0] MODE_FIXED_ADDR = 8'h44;
  localparam logic [7:0] ADDR_BASE       = 8'hC0;
  localparam logic [7:0] READ_KEYS_CMD   = 8'h42;

  // Defaults handed to the top level
  localparam int READ_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH    = 2;

  // Payload widths of the stream ports
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_READ,
    ST_CLOSE_MID,
    ST_OPEN_SECOND,
    ST_SEND_SECOND,
    ST_CLOSE_FINAL
  } step_t;

  // One classified tick, as held in the queue
  typedef struct packed {
    logic       start_ok;
    logic [1:0] command;
    logic [3:0] address;
    logic [7:0] data;
    logic       dio_in;
    logic [7:0] first_byte;
  } req_t;

  // One result, strobe_res in bit 0
  typedef struct packed {
    logic [7:0] keys;
    logic       done_res;
    logic       busy_res;
    logic       dio_drive;
    logic       dio_out;
    logic       clock_res;
    logic       strobe_res;
  } res_t;

endpackage

@@ rtl/lkp_front.sv @@
// Front end of the panel serial master: unpacks an input tick and classifies it.
// Depends on lkp_pkg for the command codes and the request record.
module lkp_front
  import lkp_pkg::*;
(
  input  logic [IN_TDATA_W-1:0] tdata,
  output req_t                  req
);

  logic       start_req;
  logic [1:0] command;
  logic [3:0] address;
  logic [7:0] data;

  assign start_req = tdata[0];
  assign command   = tdata[2:1];
  assign address   = tdata[6:3];
  assign data      = tdata[14:7];

  // Classify the request and pick the first byte of its frame
  always_comb begin
    req.command    = command;
    req.address    = address;
    req.data       = data;
    req.dio_in     = tdata[15];
    req.start_ok   = 1'b0;
    req.first_byte = READ_KEYS_CMD;
    case (command)
      CMD_SEND: begin
        req.start_ok   = start_req;
        req.first_byte = data;
      end
      CMD_WRITE: begin
        req.start_ok   = start_req;
        req.first_byte = MODE_FIXED_ADDR;
      end
      CMD_READ: begin
        req.start_ok   = start_req;
        req.first_byte = READ_KEYS_CMD;
      end
      default: begin
        req.start_ok = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/lkp_queue.sv @@
// Short request queue between the front end and the sequencer.
// Depends on lkp_pkg for the request record.
module lkp_queue
  import lkp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic empty,
  output req_t pop_req
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

  req_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign pop_req = mem[rd_ptr];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("request queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("request queue read while empty");
`endif

endmodule

@@ rtl/lkp_seq.sv @@
// Back end of the panel serial master: the bus sequencer and the result register.
// Depends on lkp_pkg for the step type, command codes and records.
module lkp_seq
  import lkp_pkg::*;
#(
  parameter int READ_BYTES = READ_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  req_t q_req,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam logic [2:0] READ_BYTES_C = 3'(READ_BYTES);

  step_t      step, step_next;
  logic       bit_phase, bit_phase_next;
  logic [2:0] bit_count, bit_count_next;
  logic [1:0] byte_count, byte_count_next;
  logic [7:0] shreg, shreg_next;
  logic [7:0] keyacc, keyacc_next;
  logic [1:0] lat_cmd, lat_cmd_next;
  logic [3:0] lat_addr, lat_addr_next;
  logic [7:0] lat_data, lat_data_next;
  res_t       res;
  logic       adv;

  // Take one queued tick whenever the result register is free or being drained
  assign adv   = !q_empty && (!out_valid || out_ready);
  assign q_pop = adv;

  // Step the sequence for one tick
  always_comb begin
    step_next       = step;
    bit_phase_next  = bit_phase;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    shreg_next      = shreg;
    keyacc_next     = keyacc;
    lat_cmd_next    = lat_cmd;
    lat_addr_next   = lat_addr;
    lat_data_next   = lat_data;
    res.strobe_res  = 1'b1;
    res.clock_res   = 1'b1;
    res.dio_out     = 1'b0;
    res.dio_drive   = 1'b1;
    res.busy_res    = 1'b0;
    res.done_res    = 1'b0;
    res.keys        = 8'd0;
    case (step)
      ST_IDLE: begin
        if (q_req.start_ok) begin
          lat_cmd_next    = q_req.command;
          lat_addr_next   = q_req.address;
          lat_data_next   = q_req.data;
          keyacc_next     = 8'd0;
          shreg_next      = q_req.first_byte;
          bit_count_next  = 3'd0;
          byte_count_next = 2'd0;
          bit_phase_next  = 1'b0;
          step_next       = ST_SEND;
          res.strobe_res  = 1'b0;
          res.busy_res    = 1'b1;
        end
      end
      ST_SEND, ST_SEND_SECOND: begin
        res.strobe_res = 1'b0;
        res.busy_res   = 1'b1;
        res.dio_out    = shreg[0];
        if (!bit_phase) begin
          res.clock_res  = 1'b0;
          bit_phase_next = 1'b1;
        end else begin
          bit_phase_next = 1'b0;
          shreg_next     = {1'b0, shreg[7:1]};
          if (bit_count == 3'd7) begin
            bit_count_next = 3'd0;
            if (step == ST_SEND) begin
              case (lat_cmd)
                CMD_WRITE: step_next = ST_CLOSE_MID;
                CMD_READ: begin
                  step_next       = ST_READ;
                  shreg_next      = 8'd0;
                  byte_count_next = 2'd0;
                end
                default: step_next = ST_CLOSE_FINAL;
              endcase
            end else if (byte_count == 2'd0) begin
              byte_count_next = 2'd1;
              shreg_next      = lat_data;
            end else begin
              step_next = ST_CLOSE_FINAL;
            end
          end else begin
            bit_count_next = bit_count + 3'd1;
          end
        end
      end
      ST_READ: begin
        res.strobe_res = 1'b0;
        res.busy_res   = 1'b1;
        res.dio_drive  = 1'b0;
        if (!bit_phase) begin
          res.clock_res  = 1'b0;
          shreg_next     = shreg | (8'(q_req.dio_in) << bit_count);
          bit_phase_next = 1'b1;
        end else begin
          bit_phase_next = 1'b0;
          if (bit_count == 3'd7) begin
            keyacc_next    = keyacc | (shreg << {byte_count, 1'b0});
            shreg_next     = 8'd0;
            bit_count_next = 3'd0;
            if (({1'b0, byte_count} + 3'd1) >= READ_BYTES_C) begin
              step_next = ST_CLOSE_FINAL;
            end else begin
              byte_count_next = byte_count + 2'd1;
            end
          end else begin
            bit_count_next = bit_count + 3'd1;
          end
        end
      end
      ST_CLOSE_MID: begin
        res.busy_res = 1'b1;
        step_next    = ST_OPEN_SECOND;
      end
      ST_OPEN_SECOND: begin
        res.strobe_res  = 1'b0;
        res.busy_res    = 1'b1;
        shreg_next      = ADDR_BASE | {4'd0, lat_addr};
        byte_count_next = 2'd0;
        bit_count_next  = 3'd0;
        bit_phase_next  = 1'b0;
        step_next       = ST_SEND_SECOND;
      end
      ST_CLOSE_FINAL: begin
        res.busy_res = 1'b1;
        res.done_res = 1'b1;
        res.keys     = (lat_cmd == CMD_READ) ? keyacc : 8'd0;
        step_next    = ST_IDLE;
      end
      default: begin
        step_next = ST_IDLE;
      end
    endcase
  end

  // Hold the sequence state, advance only on a taken tick
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= ST_IDLE;
      bit_phase  <= 1'b0;
      bit_count  <= 3'd0;
      byte_count <= 2'd0;
      shreg      <= 8'd0;
      keyacc     <= 8'd0;
      lat_cmd    <= CMD_SEND;
      lat_addr   <= 4'd0;
      lat_data   <= 8'd0;
    end else if (adv) begin
      step       <= step_next;
      bit_phase  <= bit_phase_next;
      bit_count  <= bit_count_next;
      byte_count <= byte_count_next;
      shreg      <= shreg_next;
      keyacc     <= keyacc_next;
      lat_cmd    <= lat_cmd_next;
      lat_addr   <= lat_addr_next;
      lat_data   <= lat_data_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

`ifndef ASSERT_OFF
  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |-> out_res.busy_res && out_res.strobe_res)
    else $error("done reported inside an open frame");
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.busy_res |->
      out_res.strobe_res && out_res.clock_res && out_res.dio_drive)
    else $error("bus pins not released while idle");
  a_read_release: assert property (@(posedge clk) disable iff (rst)
    adv && step == ST_READ |=> !out_res.dio_drive && !out_res.strobe_res)
    else $error("data pin driven during a key read");
  a_keys_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.done_res |-> out_res.keys == 8'd0)
    else $error("key word shown outside the done tick");
`endif

endmodule

@@ rtl/led_key_panel_serial_master_top.sv @@
// An accepted tick is held in the request queue, then its result is registered in the result register.
// One tick per clock cycle while m_tready does not stall the result register; the sequencer steps once per queued tick.
// A two-entry request queue parts the input side from the sequencer and result register.
// Reset (rst, synchronous, active high) empties the queue, drops the result
// and returns the sequencer to idle; the result data itself is not cleared.
// Depends on lkp_pkg, lkp_front, lkp_queue and lkp_seq.
module led_key_panel_serial_master_top
  import lkp_pkg::*;
#(
  parameter int READ_BYTES = READ_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // start_req[0], command[2:1], address[6:3], data[14:7], dio_in[15]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // strobe_res[0], clock_res[1], dio_out[2], dio_drive[3], busy_res[4],
  // done_res[5], keys[13:6], zero pad[15:14]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  req_t in_req;
  req_t q_req;
  res_t out_res;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic push;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;
  assign m_tdata  = {2'b00, out_res};

  lkp_front u_front (
    .tdata (s_tdata),
    .req   (in_req)
  );

  lkp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (in_req),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_req  (q_req)
  );

  lkp_seq #(
    .READ_BYTES (READ_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

endmodule
